@@ design/mfsk_tone_pair_detector_macros.svh @@
// Assertion macros for the tone pair detector checker.
`ifndef MFSK_TONE_PAIR_DETECTOR_MACROS_SVH
`define MFSK_TONE_PAIR_DETECTOR_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define MFSK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfsk assertion failed");

// Next-cycle implication, quiet while reset is high.
`define MFSK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfsk assertion failed");

`endif

@@ design/mfsk_pkg.sv @@
// Shared constants for the MFSK tone pair detector.
`default_nettype none

package mfsk_pkg;

   // Tone counts of the two modes
   localparam int TONES_THROB  = 9;
   localparam int TONES_THROBX = 11;
   localparam int TONES_MAX    = TONES_THROBX;

   // Tone index width and largest legal index
   localparam int TONE_W = 4;
   localparam logic [TONE_W-1:0] TONE_LAST_THROB  = TONE_W'(TONES_THROB - 1);
   localparam logic [TONE_W-1:0] TONE_LAST_THROBX = TONE_W'(TONES_THROBX - 1);

   // Metric and divider
   localparam int METRIC_W   = 16;
   localparam int QSTEP_W    = $clog2(METRIC_W);
   localparam int AVG_SHIFT  = 3;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int THR_W      = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE_EXTENDED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_SIDEBAND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_THRESHOLD = 2'd2;

endpackage

`default_nettype wire

@@ design/mfsk_if.sv @@
// Handshake channels of the MFSK tone pair detector: symbol, result and register write.
`default_nettype none

interface mfsk_req_if #(parameter int MAG_WIDTH = 16) ();
   logic                 valid;
   logic                 ready;
   logic [MAG_WIDTH-1:0] mag_0;
   logic [MAG_WIDTH-1:0] mag_1;
   logic [MAG_WIDTH-1:0] mag_2;
   logic [MAG_WIDTH-1:0] mag_3;
   logic [MAG_WIDTH-1:0] mag_4;
   logic [MAG_WIDTH-1:0] mag_5;
   logic [MAG_WIDTH-1:0] mag_6;
   logic [MAG_WIDTH-1:0] mag_7;
   logic [MAG_WIDTH-1:0] mag_8;
   logic [MAG_WIDTH-1:0] mag_9;
   logic [MAG_WIDTH-1:0] mag_10;

   modport source (
      output valid, mag_0, mag_1, mag_2, mag_3, mag_4, mag_5, mag_6, mag_7, mag_8,
             mag_9, mag_10,
      input  ready
   );
   modport sink (
      input  valid, mag_0, mag_1, mag_2, mag_3, mag_4, mag_5, mag_6, mag_7, mag_8,
             mag_9, mag_10,
      output ready
   );
endinterface

interface mfsk_rsp_if import mfsk_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TONE_W-1:0]   tone_low;
   logic [TONE_W-1:0]   tone_high;
   logic [TONE_W-1:0]   strongest_tone;
   logic [METRIC_W-1:0] quality_metric;
   logic                metric_ok;

   modport source (
      output valid, tone_low, tone_high, strongest_tone, quality_metric, metric_ok,
      input  ready
   );
   modport sink (
      input  valid, tone_low, tone_high, strongest_tone, quality_metric, metric_ok,
      output ready
   );
endinterface

interface mfsk_csr_if import mfsk_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/mfsk_alu.sv @@
// Shared subtract and compare unit used by the scan, eval, divide and finish steps of the detector sequencer.
`default_nettype none

module mfsk_alu #(
   parameter int W = 37
) (
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   output logic      [W-1:0] diff,
   output logic              ge
);

   logic borrow;

   // a - b with borrow out; no borrow means a >= b
   assign {borrow, diff} = {1'b0, a} - {1'b0, b};
   assign ge = ~borrow;

endmodule

`default_nettype wire

@@ design/mfsk_tone_pair_detector.sv @@
// Top level of the MFSK tone pair detector with decaying SNR quality metric.
//
//   channel | dir | beat contents                                   | ready rule
//   --------+-----+-------------------------------------------------+--------------------
//   req_bus | in  | mag_0 .. mag_10 tone magnitudes                 | high only when idle
//   rsp_bus | out | tone_low, tone_high, strongest_tone, metric, ok  | output register
//   csr_bus | in  | register index, write data                      | always high
//
// A symbol beat, N = 9 (Throb) or 11 (ThrobX) tones, goes through two passes over
// the stored tones on the shared compare unit, then a 16-step restoring divide on
// the same unit. Zero noise skips the divide, a saturated ratio skips the divide
// steps. The next symbol is taken once the sequencer is back in idle.
// Reset (synchronous, active high) clears configuration, the metric average and the
// result valid. A stalled result holds while the next symbol runs; that symbol then
// waits in its last step until the output register is taken.
`default_nettype none

module mfsk_tone_pair_detector import mfsk_pkg::*; #(
   parameter int MAG_WIDTH        = 16,
   parameter int METRIC_FRAC_BITS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mfsk_req_if.sink    req_bus,
   mfsk_rsp_if.source  rsp_bus,
   mfsk_csr_if.sink    csr_bus
);

   // Datapath widths: magnitude sum over all tones, pair sum, numerator, shifted divisor
   localparam int SUM_W  = MAG_WIDTH + $clog2(TONES_MAX + 1);
   localparam int PAIR_W = MAG_WIDTH + 1;
   localparam int NUM_W  = PAIR_W + 4 + METRIC_FRAC_BITS;
   localparam int DEN_W  = SUM_W + 1 + METRIC_W;
   localparam int ALU_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
   localparam int AVG_W  = METRIC_W + AVG_SHIFT + 1;

   // Sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCAN1  = 4'd1;
   localparam logic [3:0] ST_SCAN2  = 4'd2;
   localparam logic [3:0] ST_EVAL   = 4'd3;
   localparam logic [3:0] ST_MUL    = 4'd4;
   localparam logic [3:0] ST_OVF    = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_AVG    = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   logic [3:0]           state_ff, state_in;

   // Configuration
   logic                 ext_ff, ext_in;
   logic                 rev_ff, rev_in;
   logic [THR_W-1:0]     thr_ff, thr_in;

   // Symbol store and scan registers
   logic [MAG_WIDTH-1:0] mag_ff [TONES_MAX];
   logic [TONE_W-1:0]    idx_ff, idx_in;
   logic [MAG_WIDTH-1:0] max1_ff, max1_in;
   logic [MAG_WIDTH-1:0] max2_ff, max2_in;
   logic [TONE_W-1:0]    t1_ff, t1_in;
   logic [TONE_W-1:0]    t2_ff, t2_in;
   logic [SUM_W-1:0]     total_ff, total_in;

   // Pair decision and ratio
   logic [TONE_W-1:0]    lo_ff, lo_in;
   logic [TONE_W-1:0]    hi_ff, hi_in;
   logic [PAIR_W-1:0]    pair_ff, pair_in;
   logic [SUM_W-1:0]     noise_ff, noise_in;
   logic [ALU_W-1:0]     rem_ff, rem_in;
   logic [ALU_W-1:0]     dsh_ff, dsh_in;
   logic [METRIC_W-1:0]  quo_ff, quo_in;
   logic [QSTEP_W-1:0]   step_ff, step_in;
   logic [METRIC_W-1:0]  avg_ff, avg_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TONE_W-1:0]    rsp_lo_ff, rsp_hi_ff, rsp_strong_ff;
   logic [METRIC_W-1:0]  rsp_metric_ff;
   logic                 rsp_ok_ff;
   logic                 rsp_load;

   // Shared unit
   logic [ALU_W-1:0]     alu_a, alu_b, alu_diff;
   logic                 alu_ge;

   // Helpers
   logic                 req_fire;
   logic [TONE_W-1:0]    last_idx;
   logic [MAG_WIDTH-1:0] cur_mag;
   logic                 single;
   logic [TONE_W-1:0]    t2_eff;
   logic                 same;
   logic [MAG_WIDTH-1:0] m2_val;
   logic [TONE_W-1:0]    lo_raw, hi_raw;
   logic [ALU_W-1:0]     pair_x8, pair_scaled;
   logic [AVG_W-1:0]     avg_sum;

   mfsk_alu #(.W(ALU_W)) u_alu (
      .a    (alu_a),
      .b    (alu_b),
      .diff (alu_diff),
      .ge   (alu_ge)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign last_idx = ext_ff ? TONE_LAST_THROBX : TONE_LAST_THROB;
   assign cur_mag  = mag_ff[idx_ff];

   // Pair decision, valid in the eval step (unit compares twice the runner-up with the top)
   assign single  = !ext_ff && !alu_ge;
   assign t2_eff  = single ? t1_ff : t2_ff;
   assign same    = (t2_eff == t1_ff);
   assign m2_val  = same ? max1_ff : max2_ff;
   assign lo_raw  = (t1_ff > t2_eff) ? t2_eff : t1_ff;
   assign hi_raw  = (t1_ff > t2_eff) ? t1_ff : t2_eff;

   // pair * (tones - 2) by shift and add or subtract: 9 for ThrobX, 7 for Throb
   assign pair_x8     = ALU_W'(pair_ff) << 3;
   assign pair_scaled = ext_ff ? (pair_x8 + ALU_W'(pair_ff)) : (pair_x8 - ALU_W'(pair_ff));

   // 7 * avg + ratio, then drop three bits
   assign avg_sum = (AVG_W'(avg_ff) << AVG_SHIFT) - AVG_W'(avg_ff) + AVG_W'(quo_ff);

   // Steer the shared unit
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff)
         ST_SCAN1: begin
            alu_a = ALU_W'(max1_ff);
            alu_b = ALU_W'(cur_mag);
         end
         ST_SCAN2: begin
            alu_a = ALU_W'(max2_ff);
            alu_b = ALU_W'(cur_mag);
         end
         ST_EVAL: begin
            alu_a = ALU_W'(max2_ff) << 1;
            alu_b = ALU_W'(max1_ff);
         end
         ST_OVF, ST_DIV: begin
            alu_a = rem_ff;
            alu_b = dsh_ff;
         end
         ST_FINISH: begin
            alu_a = ALU_W'(avg_ff);
            alu_b = ALU_W'(thr_ff) << METRIC_FRAC_BITS;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      max1_in  = max1_ff;
      max2_in  = max2_ff;
      t1_in    = t1_ff;
      t2_in    = t2_ff;
      total_in = total_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      pair_in  = pair_ff;
      noise_in = noise_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      avg_in   = avg_ff;
      rsp_load = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in   = '0;
               max1_in  = '0;
               max2_in  = '0;
               t1_in    = '0;
               t2_in    = '0;
               total_in = '0;
               state_in = ST_SCAN1;
            end
         end
         ST_SCAN1: begin
            // strongest tone, earliest wins on ties; also sum every tone
            if (!alu_ge) begin
               max1_in = cur_mag;
               t1_in   = idx_ff;
            end
            total_in = total_ff + SUM_W'(cur_mag);
            if (idx_ff == last_idx) begin
               idx_in   = '0;
               state_in = ST_SCAN2;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SCAN2: begin
            // runner-up among the other tones
            if (idx_ff != t1_ff && !alu_ge) begin
               max2_in = cur_mag;
               t2_in   = idx_ff;
            end
            if (idx_ff == last_idx) begin
               state_in = ST_EVAL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EVAL: begin
            pair_in  = PAIR_W'(max1_ff) + PAIR_W'(m2_val);
            noise_in = total_ff - SUM_W'(max1_ff) - (same ? '0 : SUM_W'(max2_ff));
            if (rev_ff) begin
               lo_in = last_idx - hi_raw;
               hi_in = last_idx - lo_raw;
            end else begin
               lo_in = lo_raw;
               hi_in = hi_raw;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (noise_ff == '0) begin
               quo_in   = (pair_ff != '0) ? '1 : '0;
               state_in = ST_AVG;
            end else begin
               rem_in   = pair_scaled << METRIC_FRAC_BITS;
               dsh_in   = ALU_W'({noise_ff, 1'b0}) << METRIC_W;
               state_in = ST_OVF;
            end
         end
         ST_OVF: begin
            // saturate when the quotient needs more than the metric width
            if (alu_ge) begin
               quo_in   = '1;
               state_in = ST_AVG;
            end else begin
               quo_in   = '0;
               dsh_in   = dsh_ff >> 1;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (alu_ge) begin
               rem_in = alu_diff;
            end
            quo_in  = {quo_ff[METRIC_W-2:0], alu_ge};
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == QSTEP_W'(METRIC_W - 1)) begin
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            avg_in   = avg_sum[AVG_SHIFT +: METRIC_W];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Register writes
   always_comb begin
      ext_in = ext_ff;
      rev_in = rev_ff;
      thr_in = thr_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_MODE_EXTENDED:    ext_in = csr_bus.data[0];
            CSR_REVERSE_SIDEBAND: rev_in = csr_bus.data[0];
            CSR_METRIC_THRESHOLD: thr_in = csr_bus.data[THR_W-1:0];
            default: begin
               ext_in = ext_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ext_ff       <= 1'b0;
         rev_ff       <= 1'b0;
         thr_ff       <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ext_ff       <= ext_in;
         rev_ff       <= rev_in;
         thr_ff       <= thr_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mag_ff[0]  <= req_bus.mag_0;
         mag_ff[1]  <= req_bus.mag_1;
         mag_ff[2]  <= req_bus.mag_2;
         mag_ff[3]  <= req_bus.mag_3;
         mag_ff[4]  <= req_bus.mag_4;
         mag_ff[5]  <= req_bus.mag_5;
         mag_ff[6]  <= req_bus.mag_6;
         mag_ff[7]  <= req_bus.mag_7;
         mag_ff[8]  <= req_bus.mag_8;
         mag_ff[9]  <= req_bus.mag_9;
         mag_ff[10] <= req_bus.mag_10;
      end
      idx_ff   <= idx_in;
      max1_ff  <= max1_in;
      max2_ff  <= max2_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      total_ff <= total_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      pair_ff  <= pair_in;
      noise_ff <= noise_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      if (rsp_load) begin
         rsp_lo_ff     <= lo_ff;
         rsp_hi_ff     <= hi_ff;
         rsp_strong_ff <= t1_ff;
         rsp_metric_ff <= avg_ff;
         rsp_ok_ff     <= alu_ge;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.tone_low       = rsp_lo_ff;
   assign rsp_bus.tone_high      = rsp_hi_ff;
   assign rsp_bus.strongest_tone = rsp_strong_ff;
   assign rsp_bus.quality_metric = rsp_metric_ff;
   assign rsp_bus.metric_ok      = rsp_ok_ff;

endmodule

`default_nettype wire

@@ design/mfsk_checker.sv @@
// Port-level checks for the MFSK tone pair detector and their bind.
`default_nettype none
`include "mfsk_tone_pair_detector_macros.svh"

module mfsk_checker import mfsk_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [TONE_W-1:0]   tone_low,
   input wire logic [TONE_W-1:0]   tone_high,
   input wire logic [TONE_W-1:0]   strongest_tone,
   input wire logic [METRIC_W-1:0] quality_metric,
   input wire logic                metric_ok
);

   // ready drops after a symbol beat is taken
   `MFSK_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // pair comes out ordered
   `MFSK_ASSERT_IMPLY(a_pair_ordered, clock, reset, rsp_valid, tone_low <= tone_high)

   // no index past the last ThrobX tone
   `MFSK_ASSERT_IMPLY(a_tone_range, clock, reset, rsp_valid, (strongest_tone <= TONE_LAST_THROBX) && (tone_high <= TONE_LAST_THROBX))

   // stalled result holds
   `MFSK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(tone_low) && $stable(tone_high) && $stable(strongest_tone) && $stable(quality_metric) && $stable(metric_ok))

endmodule

bind mfsk_tone_pair_detector mfsk_checker u_mfsk_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .tone_low       (rsp_bus.tone_low),
   .tone_high      (rsp_bus.tone_high),
   .strongest_tone (rsp_bus.strongest_tone),
   .quality_metric (rsp_bus.quality_metric),
   .metric_ok      (rsp_bus.metric_ok)
);

`default_nettype wire

@@ tb/tb_mfsk_tone_pair_detector.sv @@
// Self-checking testbench for the MFSK tone pair detector: directed and random symbols.
`timescale 1ns / 100ps

module tb_mfsk_tone_pair_detector;
   import mfsk_pkg::*;

   localparam int MAG_W          = 16;
   localparam int FRAC_BITS      = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int MAX_GAP        = 40;
   localparam int MAX_PRINTS     = 100;

   // Index 3 decodes to no register; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef logic [TONES_MAX-1:0][MAG_W-1:0] mags_t;

   typedef struct packed {
      logic [TONE_W-1:0]   low;
      logic [TONE_W-1:0]   high;
      logic [TONE_W-1:0]   strongest;
      logic [METRIC_W-1:0] metric;
      logic                ok;
   } pair_result_t;

   // Scoreboard: mirrors configuration and metric average, predicts one result per
   // symbol beat and checks result beats in order.
   class tone_pair_scoreboard;
      bit                  extended;
      bit                  mirrored;
      logic [THR_W-1:0]    threshold;
      logic [METRIC_W-1:0] avg;
      pair_result_t        expected_q[$];
      int                  errors;
      int                  checked;

      function new();
         extended  = 0;
         mirrored  = 0;
         threshold = '0;
         avg       = '0;
         errors    = 0;
         checked   = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Only the low bits of each register are kept; unmapped indexes are dropped.
      function void apply_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MODE_EXTENDED:    extended  = data[0];
            CSR_REVERSE_SIDEBAND: mirrored  = data[0];
            CSR_METRIC_THRESHOLD: threshold = data[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_symbol(mags_t m);
         int unsigned  tones, first, second, lo, hi, i;
         logic [31:0]  max1, max2;
         logic [63:0]  pair, noise, ratio, next_avg;
         pair_result_t r;
         tones  = extended ? TONES_THROBX : TONES_THROB;
         first  = 0;
         second = 0;
         max1   = 0;
         max2   = 0;
         // strongest tone: strictly above zero, earliest index wins ties
         for (i = 0; i < tones; i++) begin
            if (m[i] > max1) begin
               max1  = m[i];
               first = i;
            end
         end
         for (i = 0; i < tones; i++) begin
            if (i != first && m[i] > max2) begin
               max2   = m[i];
               second = i;
            end
         end
         r.strongest = TONE_W'(first);
         // single-tone rule applies in nine-tone mode only
         if (!extended && max1 > 2 * max2)
            second = first;
         lo = (first < second) ? first : second;
         hi = (first < second) ? second : first;
         pair  = 64'(m[lo]) + 64'(m[hi]);
         noise = 0;
         for (i = 0; i < tones; i++)
            if (i != lo && i != hi)
               noise += 64'(m[i]);
         if (noise == 0) begin
            ratio = (pair != 0) ? 64'hFFFF : 64'h0;
         end else begin
            ratio = ((pair * 64'(tones - 2)) << FRAC_BITS) / (2 * noise);
            if (ratio > 64'hFFFF)
               ratio = 64'hFFFF;
         end
         next_avg = (64'(avg) * 7 + ratio) >> AVG_SHIFT;
         avg      = METRIC_W'(next_avg);
         if (mirrored) begin
            r.low  = TONE_W'(tones - 1 - hi);
            r.high = TONE_W'(tones - 1 - lo);
         end else begin
            r.low  = TONE_W'(lo);
            r.high = TONE_W'(hi);
         end
         r.metric = avg;
         r.ok     = (32'(avg) >= (32'(threshold) << FRAC_BITS));
         expected_q.push_back(r);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         if (errors < MAX_PRINTS)
            $display("%0t result %0d: %s got %0d, expected %0d",
                     $realtime, checked, what, got, want);
         errors++;
      endtask

      task check_result(pair_result_t got);
         pair_result_t want;
         if (expected_q.size() == 0) begin
            report("unexpected result beat, tone_low", got.low, 0);
         end else begin
            want = expected_q.pop_front();
            if (got.low !== want.low)             report("tone_low", got.low, want.low);
            if (got.high !== want.high)           report("tone_high", got.high, want.high);
            if (got.strongest !== want.strongest)
               report("strongest_tone", got.strongest, want.strongest);
            if (got.metric !== want.metric)
               report("quality_metric", got.metric, want.metric);
            if (got.ok !== want.ok)               report("metric_ok", got.ok, want.ok);
         end
         checked++;
      endtask

      task finish_check();
         if (expected_q.size() != 0)
            report("results never delivered, count", expected_q.size(), 0);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   mfsk_req_if #(.MAG_WIDTH(MAG_W)) req_bus ();
   mfsk_rsp_if                      rsp_bus ();
   mfsk_csr_if                      csr_bus ();

   mfsk_tone_pair_detector #(
      .MAG_WIDTH        (MAG_W),
      .METRIC_FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tone_pair_scoreboard sb;
   int idle_pct;
   int stall_pct;
   int quiet_cycles = 0;

   always #10 clock = ~clock;

   // Receiver: drop ready at random, per cycle, at the phase's stall rate.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Sample every handshake at the rising edge; results first, since a result
   // always belongs to a symbol taken at an earlier edge.
   always @(posedge clock) begin : monitor
      mags_t        seen;
      pair_result_t got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.low       = rsp_bus.tone_low;
            got.high      = rsp_bus.tone_high;
            got.strongest = rsp_bus.strongest_tone;
            got.metric    = rsp_bus.quality_metric;
            got.ok        = rsp_bus.metric_ok;
            sb.check_result(got);
         end
         if (req_bus.valid && req_bus.ready) begin
            seen[0]  = req_bus.mag_0;
            seen[1]  = req_bus.mag_1;
            seen[2]  = req_bus.mag_2;
            seen[3]  = req_bus.mag_3;
            seen[4]  = req_bus.mag_4;
            seen[5]  = req_bus.mag_5;
            seen[6]  = req_bus.mag_6;
            seen[7]  = req_bus.mag_7;
            seen[8]  = req_bus.mag_8;
            seen[9]  = req_bus.mag_9;
            seen[10] = req_bus.mag_10;
            sb.note_symbol(seen);
         end
         if (csr_bus.valid && csr_bus.ready)
            sb.apply_write(csr_bus.index, csr_bus.data);
      end
   end

   // Watchdog: end the run if no beat of any channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[mfsk_tone_pair_detector] ERROR");
         $finish;
      end
   end

   // Entered at a falling edge; leaves valid high at the falling edge after the beat
   // so that back-to-back symbols keep valid up.
   task send_symbol(input mags_t m);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.mag_0  <= m[0];
      req_bus.mag_1  <= m[1];
      req_bus.mag_2  <= m[2];
      req_bus.mag_3  <= m[3];
      req_bus.mag_4  <= m[4];
      req_bus.mag_5  <= m[5];
      req_bus.mag_6  <= m[6];
      req_bus.mag_7  <= m[7];
      req_bus.mag_8  <= m[8];
      req_bus.mag_9  <= m[9];
      req_bus.mag_10 <= m[10];
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Hold the sender until every predicted result has been taken.
   task drain_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Random symbol. clean_pct sets the share of noiseless symbols, which drive the
   // average toward full scale; the rest mixes typical pairs, near-2x ratios, full
   // range noise, ties and corner values.
   function automatic mags_t make_symbol(int clean_pct);
      mags_t      m;
      int         a, b, i;
      logic [15:0] v;
      m = '0;
      a = $urandom_range(TONES_MAX - 1);
      b = $urandom_range(TONES_MAX - 1);
      if ($urandom_range(99) < clean_pct) begin
         if ($urandom_range(19) != 0)
            m[a] = 16'($urandom_range(65535, 1));
         if ($urandom_range(1) != 0)
            m[b] = 16'($urandom_range(65535, 1));
      end else begin
         case ($urandom_range(4))
            0: begin
               for (i = 0; i < TONES_MAX; i++)
                  m[i] = 16'($urandom_range(1200));
               m[a] = 16'($urandom_range(65535, 1500));
               m[b] = 16'($urandom_range(65535, 1500));
            end
            1: begin
               for (i = 0; i < TONES_MAX; i++)
                  m[i] = 16'($urandom_range(3));
               m[a] = 16'($urandom_range(65535, 8));
               m[b] = 16'(m[a] / 2 + $urandom_range(2) - 1);
            end
            2: begin
               for (i = 0; i < TONES_MAX; i++)
                  m[i] = 16'($urandom);
            end
            3: begin
               v = 16'($urandom_range(65535, 4));
               for (i = 0; i < TONES_MAX; i++)
                  m[i] = ($urandom_range(1) != 0) ? v : 16'($urandom_range(3));
            end
            default: begin
               for (i = 0; i < TONES_MAX; i++)
                  case ($urandom_range(4))
                     0:       m[i] = 16'h0000;
                     1:       m[i] = 16'h0001;
                     2:       m[i] = 16'h7FFF;
                     3:       m[i] = 16'h8000;
                     default: m[i] = 16'hFFFF;
                  endcase
            end
         endcase
      end
      return m;
   endfunction

   // One phase: wait until idle, program all registers (wide data where only bit 0
   // counts), then stream random symbols with a full pause halfway through.
   task run_phase(input bit ext, input bit rev, input logic [THR_W-1:0] thr,
                  input int idle, input int stall, input int count, input int clean_pct);
      int k;
      drain_results();
      write_reg(CSR_MODE_EXTENDED, {7'($urandom), ext});
      write_reg(CSR_REVERSE_SIDEBAND, {7'($urandom), rev});
      write_reg(CSR_METRIC_THRESHOLD, thr);
      idle_pct  = idle;
      stall_pct = stall;
      for (k = 0; k < count; k++) begin
         if (k == count / 2)
            drain_results();
         send_symbol(make_symbol(clean_pct));
      end
   endtask

   initial begin
      mags_t m;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.mag_0  = '0;
      req_bus.mag_1  = '0;
      req_bus.mag_2  = '0;
      req_bus.mag_3  = '0;
      req_bus.mag_4  = '0;
      req_bus.mag_5  = '0;
      req_bus.mag_6  = '0;
      req_bus.mag_7  = '0;
      req_bus.mag_8  = '0;
      req_bus.mag_9  = '0;
      req_bus.mag_10 = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = '0;
      csr_bus.data   = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      sb             = new();

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed, reset configuration: nine tones, no mirroring, threshold zero.
      m = '0;                                    // all silent: pair (0,0), zero ratio
      send_symbol(m);
      m = '1;                                    // all full scale: ties, earliest wins
      send_symbol(m);
      m = '0; m[8] = 16'hFFFF;                   // lone tone on the top index
      send_symbol(m);
      m = '0; m[0] = 16'd1;                      // smallest nonzero, no second tone
      send_symbol(m);
      m = '0; m[2] = 16'd1000; m[7] = 16'd500;   // exactly twice: still a pair
      send_symbol(m);
      m = '0; m[2] = 16'd1001; m[7] = 16'd500;   // just over twice: single tone
      send_symbol(m);
      m = {TONES_MAX{16'd10}};                   // three-way tie on top
      m[1] = 16'd3000; m[4] = 16'd3000; m[6] = 16'd3000;
      send_symbol(m);
      m = {TONES_MAX{16'd5}};                    // loud upper tones ignored here
      m[9] = 16'hFFFF; m[10] = 16'hFFFF; m[0] = 16'd100; m[1] = 16'd90;
      send_symbol(m);
      m = '0; m[3] = 16'hFFFF; m[5] = 16'hFFFF; m[0] = 16'd1;   // saturating ratio
      send_symbol(m);
      m = {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
           16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
      send_symbol(m);

      // Eleven tones, mirrored, top threshold; index 3 must be a no-op.
      drain_results();
      write_reg(CSR_MODE_EXTENDED, 8'hFF);
      write_reg(CSR_REVERSE_SIDEBAND, 8'h03);
      write_reg(CSR_METRIC_THRESHOLD, 8'hFF);
      write_reg(CSR_UNMAPPED, 8'($urandom));
      m = '0;                                    // silent: mirrors to (10,10)
      send_symbol(m);
      m = '0; m[10] = 16'd40000;                 // no single-tone rule: pair (0,10)
      send_symbol(m);
      m = '0; m[9] = 16'hFFFF; m[10] = 16'hFFFF;
      send_symbol(m);
      m = '0; m[0] = 16'd2000; m[1] = 16'd100;
      send_symbol(m);
      m = '1;
      send_symbol(m);
      m = {TONES_MAX{16'd1}}; m[5] = 16'hFFFF;
      send_symbol(m);

      // Random phases: no idling, sender idle, receiver stall, both, and none again.
      run_phase(1'b0, 1'b0, 8'd0, 0, 0, 130, 15);
      run_phase(1'b1, 1'b1, 8'hFF, 62, 0, 110, 85);
      run_phase(1'b0, 1'b1, 8'($urandom), 0, 62, 110, 30);
      run_phase(1'b1, 1'b0, 8'($urandom_range(60)), 26, 26, 110, 20);
      run_phase(1'b0, 1'b0, 8'hFF, 0, 0, 80, 90);

      // Let any stray result show up, then judge.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.finish_check();
      if (sb.errors == 0)
         $display("[mfsk_tone_pair_detector] OK");
      else
         $display("[mfsk_tone_pair_detector] ERROR");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/mfsk_pkg.sv
design/mfsk_if.sv
design/mfsk_alu.sv
design/mfsk_tone_pair_detector.sv
design/mfsk_checker.sv
tb/tb_mfsk_tone_pair_detector.sv
